>>> rtl/core/pwc_pkg.sv
// Package: shared widths, codes and payload types of the wall contact unit.
package pwc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int NORMAL_FRACTION_BITS = 14;
  localparam int TAG_WIDTH = 16;

  localparam int HW = COORD_WIDTH - 2;
  localparam int MW = HW + 1;
  localparam int GW = COORD_WIDTH + 2;
  localparam int RW = MW + 3;
  localparam int NW = NORMAL_FRACTION_BITS + 2;
  localparam int QW = NW;
  localparam int DRW = MW + 2;
  localparam int NUMW = MW + NORMAL_FRACTION_BITS + 2;
  localparam int SQ_PER = 4;
  localparam int DV_PER = 4;
  localparam int SQ_ST = (MW + SQ_PER - 1) / SQ_PER;
  localparam int DV_ST = (QW + DV_PER - 1) / DV_PER;
  localparam int MAX_REC = 6;

  localparam logic signed [NW-1:0] NORM_ONE = NW'(1) <<< NORMAL_FRACTION_BITS;

  typedef enum logic [2:0] {
    CFG_Y_LOW   = 3'd0,
    CFG_Y_HIGH  = 3'd1,
    CFG_Z_LOW   = 3'd2,
    CFG_Z_HIGH  = 3'd3,
    CFG_X_LOW   = 3'd4,
    CFG_X_HIGH  = 3'd5,
    CFG_RANGE   = 3'd6
  } pwc_cfg_t;

  typedef enum logic [2:0] {
    W_YLOW  = 3'd0,
    W_YHIGH = 3'd1,
    W_ZLOW  = 3'd2,
    W_ZHIGH = 3'd3,
    W_XLOW  = 3'd4,
    W_XHIGH = 3'd5,
    W_EDGE1 = 3'd6,
    W_EDGE2 = 3'd7
  } pwc_wall_t;

  typedef enum logic [1:0] {
    K_OUTER,
    K_BELOW,
    K_EDGE,
    K_NONE
  } pwc_kind_t;

  typedef struct packed {
    logic [TAG_WIDTH-1:0]          particle_tag;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic [COORD_WIDTH-2:0]        diameter;
  } pwc_in_t;

  typedef struct packed {
    logic [TAG_WIDTH-1:0]          particle_tag_out;
    logic [2:0]                    wall_code;
    logic signed [COORD_WIDTH-1:0] gap;
    logic                          in_contact;
    logic                          attract;
    logic signed [NW-1:0]          normal_x;
    logic signed [NW-1:0]          normal_y;
    logic signed [NW-1:0]          normal_z;
    logic                          last;
  } pwc_out_t;

  typedef struct packed {
    logic [TAG_WIDTH-1:0] tag;
    logic [HW-1:0]        half;
    pwc_kind_t            kind;
    logic                 edge_hi;
    logic signed [GW-1:0] g_ylo;
    logic signed [GW-1:0] g_yhi;
    logic signed [GW-1:0] g_xlo;
    logic signed [GW-1:0] g_xhi;
    logic signed [GW-1:0] g_zlo;
    logic signed [GW-1:0] g_zhi;
    logic signed [GW-1:0] g_edge;
    logic                 dxneg;
    logic [HW-1:0]        ax;
    logic [HW-1:0]        az;
    logic [2*HW-1:0]      sqx;
    logic [2*HW-1:0]      sqz;
    logic [2*MW-1:0]      rad;
    logic [RW-1:0]        srem;
    logic [MW-1:0]        sroot;
    logic [MW-1:0]        mag;
    logic [DRW-1:0]       rrx;
    logic [DRW-1:0]       rrz;
    logic [QW-1:0]        nlx;
    logic [QW-1:0]        nlz;
    logic [QW-1:0]        qx;
    logic [QW-1:0]        qz;
  } pwc_item_t;

endpackage

>>> rtl/core/particle_wall_contact_detect_unit.sv
// Top level: pipelined particle to duct wall contact detection.
//
//  channel   direction  handshake                      payload
//  particle  in         particle_valid / particle_stall pwc_in_t
//  contact   out        contact_valid / contact_stall   pwc_out_t
//  cfg       in         cfg_we                          cfg_index, cfg_data
//
// A particle enters every cycle while the pipeline moves; results leave one record
// per cycle while contact_stall is low, 2 to 6 records per particle, so the sustained
// rate follows the record count per particle, set by the single output record port.
// The square root takes 4 bits a stage and the divide 4 bits a stage.
// Reset is synchronous and clears valid bits and the configuration registers.
// A stall freezes the pipeline once its last stage is full; nothing is lost or repeated.
module particle_wall_contact_detect_unit
  import pwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   particle_valid,
  output logic                   particle_stall,
  input  pwc_in_t                particle,
  output logic                   contact_valid,
  input  logic                   contact_stall,
  output pwc_out_t               contact,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int I_SQ0 = 3;
  localparam int I_DSET = I_SQ0 + SQ_ST;
  localparam int I_DV0 = I_DSET + 1;
  localparam int NI = I_DV0 + DV_ST;

  logic signed [COORD_WIDTH-1:0] y_wall_low, y_wall_high, z_wall_low, z_wall_high;
  logic signed [COORD_WIDTH-1:0] x_edge_low, x_edge_high;
  logic [COORD_WIDTH-2:0]        attraction_range;

  logic      in_valid;
  pwc_in_t   in_q;
  logic      pvalid [NI];
  pwc_item_t pipe [NI];
  pwc_item_t pipe_next [NI];
  logic      adv;
  logic      take;

  pwc_out_t  recs [MAX_REC];
  pwc_out_t  recs_next [MAX_REC];
  logic [2:0] cnt, cnt_next, ptr;
  logic       sval;
  logic       rec_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      y_wall_low <= '0;
      y_wall_high <= '0;
      z_wall_low <= '0;
      z_wall_high <= '0;
      x_edge_low <= '0;
      x_edge_high <= '0;
      attraction_range <= '0;
    end else if (cfg_we) begin
      case (pwc_cfg_t'(cfg_index))
        CFG_Y_LOW:  y_wall_low <= cfg_data;
        CFG_Y_HIGH: y_wall_high <= cfg_data;
        CFG_Z_LOW:  z_wall_low <= cfg_data;
        CFG_Z_HIGH: z_wall_high <= cfg_data;
        CFG_X_LOW:  x_edge_low <= cfg_data;
        CFG_X_HIGH: x_edge_high <= cfg_data;
        CFG_RANGE:  attraction_range <= cfg_data[COORD_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  assign rec_last = (ptr == cnt - 3'd1);
  assign take = !sval || (!contact_stall && rec_last);
  assign adv = !pvalid[NI-1] || take;
  assign particle_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv) begin
      in_valid <= particle_valid;
    end
    if (adv) begin
      in_q <= particle;
    end
  end

  for (genvar s = 0; s < NI; s++) begin : g_stage
    if (s == 0) begin : g_prep
      always_comb begin
        pwc_item_t it;
        logic signed [GW-1:0] px, py, pz, h, xel, xeh, zlo, dx, adx;
        logic top, outb, below, in1, in2, zin;
        it = '0;
        px = GW'(in_q.pos_x);
        py = GW'(in_q.pos_y);
        pz = GW'(in_q.pos_z);
        h = signed'(GW'(in_q.diameter[COORD_WIDTH-2:1]));
        xel = GW'(x_edge_low);
        xeh = GW'(x_edge_high);
        top = pz > GW'(z_wall_high) - h;
        outb = (px <= xel) || (px >= xeh);
        below = pz <= 0;
        in1 = (px > xel) && (px < xel + h);
        in2 = (px < xeh) && (px > xeh - h);
        zin = (pz > 0) && (pz < h);
        it.tag = in_q.particle_tag;
        it.half = in_q.diameter[COORD_WIDTH-2:1];
        if (top || outb) begin
          it.kind = K_OUTER;
        end else if (below) begin
          it.kind = K_BELOW;
        end else if ((in1 || in2) && zin) begin
          it.kind = K_EDGE;
        end else begin
          it.kind = K_NONE;
        end
        it.edge_hi = !in1;
        zlo = (!(top || outb) && below) ? GW'(z_wall_low) : '0;
        it.g_ylo = py - GW'(y_wall_low) - h;
        it.g_yhi = GW'(y_wall_high) - py - h;
        it.g_xlo = px - xel - h;
        it.g_xhi = xeh - px - h;
        it.g_zlo = pz - zlo - h;
        it.g_zhi = GW'(z_wall_high) - pz - h;
        dx = in1 ? px - xel : px - xeh;
        it.dxneg = dx[GW-1];
        adx = it.dxneg ? -dx : dx;
        it.ax = adx[HW-1:0];
        it.az = pz[HW-1:0];
        pipe_next[s] = it;
      end
    end else if (s == 1) begin : g_mul
      always_comb begin
        pwc_item_t it;
        it = pipe[s-1];
        it.sqx = (2*HW)'(it.ax) * (2*HW)'(it.ax);
        it.sqz = (2*HW)'(it.az) * (2*HW)'(it.az);
        pipe_next[s] = it;
      end
    end else if (s == 2) begin : g_sum
      always_comb begin
        pwc_item_t it;
        it = pipe[s-1];
        it.rad = (2*MW)'(it.sqx) + (2*MW)'(it.sqz);
        it.srem = '0;
        it.sroot = '0;
        pipe_next[s] = it;
      end
    end else if (s < I_DSET) begin : g_sqrt
      always_comb begin
        pwc_item_t it;
        logic [RW-1:0] r, t;
        logic [MW-1:0] q;
        logic [2*MW-1:0] rd;
        it = pipe[s-1];
        r = it.srem;
        q = it.sroot;
        rd = it.rad;
        for (int j = 0; j < SQ_PER; j++) begin
          if ((s - I_SQ0) * SQ_PER + j < MW) begin
            r = {r[RW-3:0], rd[2*MW-1 -: 2]};
            rd = {rd[2*MW-3:0], 2'b00};
            t = RW'({q, 2'b01});
            if (r >= t) begin
              r = r - t;
              q = {q[MW-2:0], 1'b1};
            end else begin
              q = {q[MW-2:0], 1'b0};
            end
          end
        end
        it.srem = r;
        it.sroot = q;
        it.rad = rd;
        pipe_next[s] = it;
      end
    end else if (s == I_DSET) begin : g_dset
      always_comb begin
        pwc_item_t it;
        logic [NUMW-1:0] nx, nz;
        it = pipe[s-1];
        it.mag = it.sroot;
        it.g_edge = signed'(GW'(it.sroot)) - signed'(GW'(it.half));
        nx = (NUMW'(it.ax) << (NORMAL_FRACTION_BITS + 1)) + NUMW'(it.sroot);
        nz = (NUMW'(it.az) << (NORMAL_FRACTION_BITS + 1)) + NUMW'(it.sroot);
        it.rrx = DRW'(nx[NUMW-1:QW]);
        it.rrz = DRW'(nz[NUMW-1:QW]);
        it.nlx = nx[QW-1:0];
        it.nlz = nz[QW-1:0];
        it.qx = '0;
        it.qz = '0;
        pipe_next[s] = it;
      end
    end else begin : g_div
      always_comb begin
        pwc_item_t it;
        logic [DRW-1:0] den;
        it = pipe[s-1];
        den = DRW'({it.mag, 1'b0});
        for (int j = 0; j < DV_PER; j++) begin
          if ((s - I_DV0) * DV_PER + j < QW) begin
            it.rrx = {it.rrx[DRW-2:0], it.nlx[QW-1]};
            it.rrz = {it.rrz[DRW-2:0], it.nlz[QW-1]};
            it.nlx = {it.nlx[QW-2:0], 1'b0};
            it.nlz = {it.nlz[QW-2:0], 1'b0};
            if (it.rrx >= den) begin
              it.rrx = it.rrx - den;
              it.qx = {it.qx[QW-2:0], 1'b1};
            end else begin
              it.qx = {it.qx[QW-2:0], 1'b0};
            end
            if (it.rrz >= den) begin
              it.rrz = it.rrz - den;
              it.qz = {it.qz[QW-2:0], 1'b1};
            end else begin
              it.qz = {it.qz[QW-2:0], 1'b0};
            end
          end
        end
        pipe_next[s] = it;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pvalid[s] <= 1'b0;
      end else if (adv) begin
        pvalid[s] <= (s == 0) ? in_valid : pvalid[(s == 0) ? 0 : s - 1];
      end
      if (adv) begin
        pipe[s] <= pipe_next[s];
      end
    end
  end

  function automatic pwc_out_t make_rec(input logic [TAG_WIDTH-1:0] tag,
                                        input pwc_wall_t code,
                                        input logic signed [GW-1:0] g,
                                        input logic plain,
                                        input logic [COORD_WIDTH-2:0] rng,
                                        input logic signed [NW-1:0] nx,
                                        input logic signed [NW-1:0] ny,
                                        input logic signed [NW-1:0] nz);
    pwc_out_t r;
    r.particle_tag_out = tag;
    r.wall_code = code;
    if (g[GW-1:COORD_WIDTH-1] == '0 || g[GW-1:COORD_WIDTH-1] == '1) begin
      r.gap = g[COORD_WIDTH-1:0];
    end else begin
      r.gap = {g[GW-1], {(COORD_WIDTH-1){!g[GW-1]}}};
    end
    r.in_contact = g[GW-1];
    r.attract = plain && (g < signed'(GW'(rng)));
    r.normal_x = nx;
    r.normal_y = ny;
    r.normal_z = nz;
    r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    pwc_item_t it;
    logic [QW-1:0] cx, cz;
    logic signed [NW-1:0] enx, enz;
    it = pipe[NI-1];
    cx = (it.qx > QW'(NORM_ONE)) ? QW'(NORM_ONE) : it.qx;
    cz = (it.qz > QW'(NORM_ONE)) ? QW'(NORM_ONE) : it.qz;
    enx = it.dxneg ? -signed'(cx) : signed'(cx);
    enz = signed'(cz);
    for (int i = 0; i < MAX_REC; i++) begin
      recs_next[i] = '0;
    end
    recs_next[0] = make_rec(it.tag, W_YLOW, it.g_ylo, 1'b1, attraction_range,
                            '0, NORM_ONE, '0);
    recs_next[1] = make_rec(it.tag, W_YHIGH, it.g_yhi, 1'b1, attraction_range,
                            '0, -NORM_ONE, '0);
    case (it.kind)
      K_OUTER: begin
        recs_next[2] = make_rec(it.tag, W_ZLOW, it.g_zlo, 1'b1, attraction_range,
                                '0, '0, NORM_ONE);
        recs_next[3] = make_rec(it.tag, W_ZHIGH, it.g_zhi, 1'b1, attraction_range,
                                '0, '0, -NORM_ONE);
        cnt_next = 3'd4;
      end
      K_BELOW: begin
        recs_next[2] = make_rec(it.tag, W_XLOW, it.g_xlo, 1'b1, attraction_range,
                                NORM_ONE, '0, '0);
        recs_next[3] = make_rec(it.tag, W_XHIGH, it.g_xhi, 1'b1, attraction_range,
                                -NORM_ONE, '0, '0);
        recs_next[4] = make_rec(it.tag, W_ZLOW, it.g_zlo, 1'b1, attraction_range,
                                '0, '0, NORM_ONE);
        recs_next[5] = make_rec(it.tag, W_ZHIGH, it.g_zhi, 1'b1, attraction_range,
                                '0, '0, -NORM_ONE);
        cnt_next = 3'd6;
      end
      K_EDGE: begin
        recs_next[2] = make_rec(it.tag, it.edge_hi ? W_EDGE2 : W_EDGE1, it.g_edge,
                                1'b0, attraction_range, enx, '0, enz);
        cnt_next = 3'd3;
      end
      default: begin
        cnt_next = 3'd2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sval <= 1'b0;
      ptr <= '0;
      cnt <= 3'd2;
    end else if (pvalid[NI-1] && take) begin
      sval <= 1'b1;
      ptr <= '0;
      cnt <= cnt_next;
    end else if (sval && !contact_stall) begin
      if (rec_last) begin
        sval <= 1'b0;
      end
      ptr <= ptr + 3'd1;
    end
    if (pvalid[NI-1] && take) begin
      recs <= recs_next;
    end
  end

  assign contact_valid = sval;

  always_comb begin
    contact = recs[ptr];
    contact.last = rec_last;
  end

endmodule

>>> rtl/core/pwc_check.sv
// Checker: port level properties of the wall contact unit, bound to the top level.
module pwc_check
  import pwc_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     contact_valid,
  input logic     contact_stall,
  input pwc_out_t contact
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    contact_valid && contact_stall |=> contact_valid && $stable(contact))
    else $error("stalled contact request changed");

  a_ylow_then_yhigh: assert property (@(posedge clk) disable iff (rst)
    contact_valid && !contact_stall && contact.wall_code == W_YLOW
    |=> contact_valid && contact.wall_code == W_YHIGH)
    else $error("y high record does not follow y low");

  a_last_code: assert property (@(posedge clk) disable iff (rst)
    contact_valid && contact.last |->
      contact.wall_code == W_YHIGH || contact.wall_code == W_ZHIGH ||
      contact.wall_code == W_EDGE1 || contact.wall_code == W_EDGE2)
    else $error("final record has wrong wall code");

  a_contact_sign: assert property (@(posedge clk) disable iff (rst)
    contact_valid |-> contact.in_contact == contact.gap[COORD_WIDTH-1])
    else $error("contact flag disagrees with gap sign");

  a_edge_attract: assert property (@(posedge clk) disable iff (rst)
    contact_valid && (contact.wall_code == W_EDGE1 || contact.wall_code == W_EDGE2)
    |-> !contact.attract)
    else $error("attraction flagged on edge record");

endmodule

bind particle_wall_contact_detect_unit pwc_check u_pwc_check (.*);
